### rtl/core/dpbp_pkg.sv
// shared constants, register indexes and helpers for the depth pixel back-projection
// standalone package, no dependencies
package dpbp_pkg;

  localparam int STRIDE_DEF      = 6;
  localparam int COORD_BITS_DEF  = 12;

  localparam int DEPTH_W  = 20;
  localparam int LABEL_W  = 8;
  localparam int POINT_W  = 24;
  localparam int XY_W     = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [XY_W-1:0] XY_LIMIT = 28'sd134217727;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_XY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAT_ZW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_Z = 3'd7;

  localparam logic [31:0] FOCAL_RST  = 32'h1F40_1F40;
  localparam logic [31:0] CENTRE_RST = 32'h0F00_1400;
  localparam logic [39:0] LIMITS_RST = 40'h0F000_00333;
  localparam logic [31:0] QXY_RST    = 32'h0000_0000;
  localparam logic [31:0] QZW_RST    = 32'h7FFF_0000;

  // saturate a wide signed value to the 24-bit point range
  function automatic logic [POINT_W-1:0] sat_point(input logic signed [35:0] v);
    logic [POINT_W-1:0] res;
    if (v > 36'sd8388607) begin
      res = 24'h7FFFFF;
    end else if (v < -36'sd8388608) begin
      res = 24'h800000;
    end else begin
      res = v[POINT_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/depth_pixel_backprojection.sv
// depth pixel back-projection: stride/depth filter, pinhole divide, quaternion pose
// depends on dpbp_pkg
//
//  channel | direction | ports                                          | transaction
//  in      | input     | in_valid/in_ready, depth, finite, label, col/row | one depth pixel
//  out     | output    | out_valid/out_ready, point_x/y/z, point_label   | one map point
//  cfg     | input     | cfg_valid/cfg_ready, cfg_index, cfg_data        | one register write
//
// one pixel per clock sustained while the output is taken; the dividers are bit-per-stage
// restoring dividers with a dividend of width NW (37 at 12-bit coordinates)
// the whole pipeline advances together; it holds when the output register is full
// and not taken, so a stall loses and repeats nothing
// synchronous active-low reset clears valid bits and loads register defaults
// dropped pixels travel as bubbles and never reach the output
module depth_pixel_backprojection
  import dpbp_pkg::*;
#(
  parameter int STRIDE           = STRIDE_DEF,
  parameter int PIXEL_COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [DEPTH_W-1:0]           in_depth,
  input  logic                         in_depth_finite,
  input  logic [LABEL_W-1:0]           in_label,
  input  logic [PIXEL_COORD_BITS-1:0]  in_pixel_col,
  input  logic [PIXEL_COORD_BITS-1:0]  in_pixel_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [POINT_W-1:0]    out_point_x,
  output logic signed [POINT_W-1:0]    out_point_y,
  output logic signed [POINT_W-1:0]    out_point_z,
  output logic [LABEL_W-1:0]           out_point_label,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CB    = PIXEL_COORD_BITS;
  localparam int RS    = CB + 7;                      // reciprocal shift for the stride test
  localparam longint unsigned RECIP = ((64'd1 << RS) + STRIDE - 1) / STRIDE;
  localparam int DW    = CB + 4;                      // bits of 16*col
  localparam int MAGW  = (DW > 16) ? DW : 16;         // magnitude of col*16 - cx
  localparam int PW    = MAGW + DEPTH_W;              // magnitude of the numerator
  localparam int NW    = PW + 1;                      // dividend with the rounding half
  localparam int RW    = 35;                          // rotation entry, Q2.30 with headroom
  localparam int PRW   = RW + XY_W;                   // rotation product
  localparam int SW    = 64;                          // row sum

  // configuration registers
  logic [31:0]         focal_r, centre_r, qxy_r, qzw_r;
  logic [39:0]         limits_r;
  logic signed [23:0]  tx_r, ty_r, tz_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= FOCAL_RST;
      centre_r <= CENTRE_RST;
      limits_r <= LIMITS_RST;
      qxy_r    <= QXY_RST;
      qzw_r    <= QZW_RST;
      tx_r     <= '0;
      ty_r     <= '0;
      tz_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FOCAL:   focal_r  <= cfg_data[31:0];
        CFG_CENTRE:  centre_r <= cfg_data[31:0];
        CFG_LIMITS:  limits_r <= cfg_data[39:0];
        CFG_QUAT_XY: qxy_r    <= cfg_data[31:0];
        CFG_QUAT_ZW: qzw_r    <= cfg_data[31:0];
        CFG_TRANS_X: tx_r     <= cfg_data[23:0];
        CFG_TRANS_Y: ty_r     <= cfg_data[23:0];
        CFG_TRANS_Z: tz_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [15:0] fx, fy, cx, cy;
  logic [DEPTH_W-1:0] dmin, dmax;
  assign fx   = focal_r[15:0];
  assign fy   = focal_r[31:16];
  assign cx   = centre_r[15:0];
  assign cy   = centre_r[31:16];
  assign dmin = limits_r[19:0];
  assign dmax = limits_r[39:20];

  // rotation matrix from the quaternion, two register layers; settles long before use
  logic signed [15:0] qa, qb, qc, qd;
  assign qa = qxy_r[15:0];
  assign qb = qxy_r[31:16];
  assign qc = qzw_r[15:0];
  assign qd = qzw_r[31:16];

  logic signed [31:0] aa_r, bb_r, cc_r, ab_r, cd_r, ac_r, bd_r, bc_r, ad_r;
  logic signed [RW-1:0] rot_r [0:8];

  always_ff @(posedge clk) begin
    aa_r <= qa * qa;
    bb_r <= qb * qb;
    cc_r <= qc * qc;
    ab_r <= qa * qb;
    cd_r <= qc * qd;
    ac_r <= qa * qc;
    bd_r <= qb * qd;
    bc_r <= qb * qc;
    ad_r <= qa * qd;
  end

  localparam logic signed [RW-1:0] ONE_Q30 = RW'(64'sd1 << 30);

  always_ff @(posedge clk) begin
    rot_r[0] <= ONE_Q30 - (RW'(bb_r) + RW'(cc_r)) * 2;
    rot_r[1] <= (RW'(ab_r) - RW'(cd_r)) * 2;
    rot_r[2] <= (RW'(ac_r) + RW'(bd_r)) * 2;
    rot_r[3] <= (RW'(ab_r) + RW'(cd_r)) * 2;
    rot_r[4] <= ONE_Q30 - (RW'(aa_r) + RW'(cc_r)) * 2;
    rot_r[5] <= (RW'(bc_r) - RW'(ad_r)) * 2;
    rot_r[6] <= (RW'(ac_r) - RW'(bd_r)) * 2;
    rot_r[7] <= (RW'(bc_r) + RW'(ad_r)) * 2;
    rot_r[8] <= ONE_Q30 - (RW'(aa_r) + RW'(bb_r)) * 2;
  end

  // global advance: every stage moves when the output register can take a point
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: capture pixel, reciprocal quotients for the stride test
  logic [CB+RS:0] qcol_full, qrow_full;
  assign qcol_full = (CB+RS+1)'(in_pixel_col) * (CB+RS+1)'(RECIP);
  assign qrow_full = (CB+RS+1)'(in_pixel_row) * (CB+RS+1)'(RECIP);

  logic                s1_v_r, s1_fin_r;
  logic [DEPTH_W-1:0]  s1_z_r;
  logic [LABEL_W-1:0]  s1_lbl_r;
  logic [CB-1:0]       s1_col_r, s1_row_r, s1_qc_r, s1_qr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r   <= in_valid;
      s1_fin_r <= in_depth_finite;
      s1_z_r   <= in_depth;
      s1_lbl_r <= in_label;
      s1_col_r <= in_pixel_col;
      s1_row_r <= in_pixel_row;
      s1_qc_r  <= qcol_full[CB+RS-1:RS];
      s1_qr_r  <= qrow_full[CB+RS-1:RS];
    end
  end

  // stage 2: keep decision, offsets from the optical centre
  logic keep;
  logic signed [MAGW:0] dx, dy;
  assign keep = s1_v_r && s1_fin_r && (fx != 16'd0) && (fy != 16'd0)
             && (s1_z_r > dmin) && (s1_z_r < dmax)
             && ((CB+7)'(s1_col_r) == (CB+7)'(s1_qc_r) * (CB+7)'(STRIDE))
             && ((CB+7)'(s1_row_r) == (CB+7)'(s1_qr_r) * (CB+7)'(STRIDE));
  assign dx = $signed((MAGW+1)'({s1_col_r, 4'b0000})) - $signed((MAGW+1)'(cx));
  assign dy = $signed((MAGW+1)'({s1_row_r, 4'b0000})) - $signed((MAGW+1)'(cy));

  logic                s2_v_r, s2_nx_r, s2_ny_r;
  logic [MAGW-1:0]     s2_mx_r, s2_my_r;
  logic [DEPTH_W-1:0]  s2_z_r;
  logic [LABEL_W-1:0]  s2_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r   <= keep;
      s2_nx_r  <= dx[MAGW];
      s2_ny_r  <= dy[MAGW];
      s2_mx_r  <= dx[MAGW] ? MAGW'(-dx) : dx[MAGW-1:0];
      s2_my_r  <= dy[MAGW] ? MAGW'(-dy) : dy[MAGW-1:0];
      s2_z_r   <= s1_z_r;
      s2_lbl_r <= s1_lbl_r;
    end
  end

  // stage 3: numerator magnitude
  logic                s3_v_r, s3_nx_r, s3_ny_r;
  logic [PW-1:0]       s3_px_r, s3_py_r;
  logic [DEPTH_W-1:0]  s3_z_r;
  logic [LABEL_W-1:0]  s3_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r   <= s2_v_r;
      s3_nx_r  <= s2_nx_r;
      s3_ny_r  <= s2_ny_r;
      s3_px_r  <= PW'(s2_mx_r) * PW'(s2_z_r);
      s3_py_r  <= PW'(s2_my_r) * PW'(s2_z_r);
      s3_z_r   <= s2_z_r;
      s3_lbl_r <= s2_lbl_r;
    end
  end

  // divider stage array: index 0 is the dividend with half the divisor added
  logic                dv_v_r   [0:NW];
  logic                dv_nx_r  [0:NW];
  logic                dv_ny_r  [0:NW];
  logic [NW-1:0]       dv_qx_r  [0:NW];
  logic [NW-1:0]       dv_qy_r  [0:NW];
  logic [15:0]         dv_rx_r  [0:NW];
  logic [15:0]         dv_ry_r  [0:NW];
  logic [DEPTH_W-1:0]  dv_z_r   [0:NW];
  logic [LABEL_W-1:0]  dv_lbl_r [0:NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0]   <= s3_v_r;
      dv_nx_r[0]  <= s3_nx_r;
      dv_ny_r[0]  <= s3_ny_r;
      dv_qx_r[0]  <= NW'(s3_px_r) + NW'(fx[15:1]);
      dv_qy_r[0]  <= NW'(s3_py_r) + NW'(fy[15:1]);
      dv_rx_r[0]  <= '0;
      dv_ry_r[0]  <= '0;
      dv_z_r[0]   <= s3_z_r;
      dv_lbl_r[0] <= s3_lbl_r;
    end
  end

  // quotient bit per stage, restoring; user keeps divisors stable while items fly, unchecked
  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [16:0] trial_x, trial_y, sub_x, sub_y;
    logic        bit_x, bit_y;
    assign trial_x = {dv_rx_r[i], dv_qx_r[i][NW-1]};
    assign trial_y = {dv_ry_r[i], dv_qy_r[i][NW-1]};
    assign sub_x   = trial_x - {1'b0, fx};
    assign sub_y   = trial_y - {1'b0, fy};
    assign bit_x   = trial_x >= {1'b0, fx};
    assign bit_y   = trial_y >= {1'b0, fy};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[i+1]   <= dv_v_r[i];
        dv_nx_r[i+1]  <= dv_nx_r[i];
        dv_ny_r[i+1]  <= dv_ny_r[i];
        dv_qx_r[i+1]  <= {dv_qx_r[i][NW-2:0], bit_x};
        dv_qy_r[i+1]  <= {dv_qy_r[i][NW-2:0], bit_y};
        dv_rx_r[i+1]  <= bit_x ? sub_x[15:0] : trial_x[15:0];
        dv_ry_r[i+1]  <= bit_y ? sub_y[15:0] : trial_y[15:0];
        dv_z_r[i+1]   <= dv_z_r[i];
        dv_lbl_r[i+1] <= dv_lbl_r[i];
      end
    end
  end

  // saturate the quotients and restore their signs
  logic [NW-1:0]   qx_fin, qy_fin;
  logic [XY_W-1:0] mx_sat, my_sat;
  assign qx_fin = dv_qx_r[NW];
  assign qy_fin = dv_qy_r[NW];
  assign mx_sat = (qx_fin > NW'(XY_LIMIT)) ? XY_LIMIT : qx_fin[XY_W-1:0];
  assign my_sat = (qy_fin > NW'(XY_LIMIT)) ? XY_LIMIT : qy_fin[XY_W-1:0];

  logic                     sx_v_r;
  logic signed [XY_W-1:0]   sx_x_r, sx_y_r;
  logic [DEPTH_W-1:0]       sx_z_r;
  logic [LABEL_W-1:0]       sx_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_v_r <= 1'b0;
    end else if (en) begin
      sx_v_r   <= dv_v_r[NW];
      sx_x_r   <= dv_nx_r[NW] ? -mx_sat : mx_sat;
      sx_y_r   <= dv_ny_r[NW] ? -my_sat : my_sat;
      sx_z_r   <= dv_z_r[NW];
      sx_lbl_r <= dv_lbl_r[NW];
    end
  end

  // rotation products, one row per output axis
  logic signed [XY_W-1:0] zs;
  assign zs = XY_W'(sx_z_r);

  logic                   rm_v_r;
  logic signed [PRW-1:0]  rm_p_r [0:8];
  logic [LABEL_W-1:0]     rm_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_v_r <= 1'b0;
    end else if (en) begin
      rm_v_r   <= sx_v_r;
      rm_lbl_r <= sx_lbl_r;
      for (int k = 0; k < 3; k++) begin
        rm_p_r[3*k]   <= PRW'(rot_r[3*k])   * PRW'(sx_x_r);
        rm_p_r[3*k+1] <= PRW'(rot_r[3*k+1]) * PRW'(sx_y_r);
        rm_p_r[3*k+2] <= PRW'(rot_r[3*k+2]) * PRW'(zs);
      end
    end
  end

  // first partial sum per row
  logic                   sa_v_r;
  logic signed [SW-1:0]   sa_s_r [0:2];
  logic signed [PRW-1:0]  sa_p_r [0:2];
  logic [LABEL_W-1:0]     sa_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r   <= rm_v_r;
      sa_lbl_r <= rm_lbl_r;
      for (int k = 0; k < 3; k++) begin
        sa_s_r[k] <= SW'(rm_p_r[3*k]) + SW'(rm_p_r[3*k+1]);
        sa_p_r[k] <= rm_p_r[3*k+2];
      end
    end
  end

  // second sum adds the depth term and translation in Q30
  logic signed [SW-1:0] tq [0:2];
  assign tq[0] = SW'(tx_r) <<< 30;
  assign tq[1] = SW'(ty_r) <<< 30;
  assign tq[2] = SW'(tz_r) <<< 30;

  logic                 sb_v_r;
  logic signed [SW-1:0] sb_s_r [0:2];
  logic [LABEL_W-1:0]   sb_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (en) begin
      sb_v_r   <= sa_v_r;
      sb_lbl_r <= sa_lbl_r;
      for (int k = 0; k < 3; k++) begin
        sb_s_r[k] <= sa_s_r[k] + SW'(sa_p_r[k]) + tq[k];
      end
    end
  end

  // round half up by adding 2^29 then floor shift; axis swap and negation
  localparam logic signed [SW-1:0] HALF_Q30 = SW'(64'sd1 <<< 29);
  logic signed [SW-1:0] rnd [0:2];
  logic signed [35:0]   wx, wy, wz;
  for (genvar k = 0; k < 3; k++) begin : g_rnd
    assign rnd[k] = sb_s_r[k] + HALF_Q30;
  end
  assign wx = 36'(rnd[0] >>> 30);
  assign wy = 36'(rnd[1] >>> 30);
  assign wz = 36'(rnd[2] >>> 30);

  logic                       o_v_r;
  logic signed [POINT_W-1:0]  o_x_r, o_y_r, o_z_r;
  logic [LABEL_W-1:0]         o_lbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r   <= sb_v_r;
      o_x_r   <= sat_point(-wy);
      o_y_r   <= sat_point(wz);
      o_z_r   <= sat_point(-wx);
      o_lbl_r <= sb_lbl_r;
    end
  end

  assign out_valid       = o_v_r;
  assign out_point_x     = o_x_r;
  assign out_point_y     = o_y_r;
  assign out_point_z     = o_z_r;
  assign out_point_label = o_lbl_r;

endmodule

### sim/dpbp_checker.sv
// point predictor and result checker for the depth pixel back-projection
// watches the pixel, point and register channels; depends on dpbp_pkg
module dpbp_checker
  import dpbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [DEPTH_W-1:0]        in_depth,
  input  logic                      in_depth_finite,
  input  logic [LABEL_W-1:0]        in_label,
  input  logic [11:0]               in_pixel_col,
  input  logic [11:0]               in_pixel_row,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [POINT_W-1:0]        out_point_x,
  input  logic [POINT_W-1:0]        out_point_y,
  input  logic [POINT_W-1:0]        out_point_z,
  input  logic [LABEL_W-1:0]        out_point_label,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        points_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_DEPTH = 128;

  typedef struct packed {
    logic [POINT_W-1:0] px;
    logic [POINT_W-1:0] py;
    logic [POINT_W-1:0] pz;
    logic [LABEL_W-1:0] lbl;
  } map_point_t;

  // expected points in arrival order, written at wr_ptr and read at rd_ptr
  map_point_t point_mem [0:EXP_DEPTH-1];
  int wr_ptr, rd_ptr;
  logic [31:0] focal, centre, qxy, qzw;
  logic [39:0] limits;
  longint tx, ty, tz;

  function automatic longint proj_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    if (q > 134217727) q = 134217727;
    return num < 0 ? -q : q;
  endfunction

  // divide by 2^30, round half up (floor of v + 2^29)
  function automatic longint unscale(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [POINT_W-1:0] clip24(longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[POINT_W-1:0];
  endfunction

  task automatic predict_point();
    longint fx, fy, cx, cy, dmin, dmax, z, x, y, a, b, c, d, wx, wy, wz;
    longint r0, r1, r2, r3, r4, r5, r6, r7, r8, one;
    map_point_t p;
    fx = focal[15:0]; fy = focal[31:16];
    cx = centre[15:0]; cy = centre[31:16];
    dmin = limits[19:0]; dmax = limits[39:20];
    z = in_depth;
    if (in_pixel_col % STRIDE_DEF != 0 || in_pixel_row % STRIDE_DEF != 0) return;
    if (!in_depth_finite || fx == 0 || fy == 0) return;
    if (!(z > dmin && z < dmax)) return;
    x = proj_div((16 * longint'(in_pixel_col) - cx) * z, fx);
    y = proj_div((16 * longint'(in_pixel_row) - cy) * z, fy);
    a = longint'(signed'(qxy[15:0])); b = longint'(signed'(qxy[31:16]));
    c = longint'(signed'(qzw[15:0])); d = longint'(signed'(qzw[31:16]));
    one = 64'sd1 <<< 30;
    r0 = one - 2 * (b * b + c * c); r1 = 2 * (a * b - d * c); r2 = 2 * (a * c + d * b);
    r3 = 2 * (a * b + d * c); r4 = one - 2 * (a * a + c * c); r5 = 2 * (b * c - d * a);
    r6 = 2 * (a * c - d * b); r7 = 2 * (b * c + d * a); r8 = one - 2 * (a * a + b * b);
    wx = unscale(r0 * x + r1 * y + r2 * z + tx * one);
    wy = unscale(r3 * x + r4 * y + r5 * z + ty * one);
    wz = unscale(r6 * x + r7 * y + r8 * z + tz * one);
    p.px = clip24(-wy); p.py = clip24(wz); p.pz = clip24(-wx); p.lbl = in_label;
    point_mem[wr_ptr % EXP_DEPTH] <= p;
    wr_ptr <= wr_ptr + 1;
  endtask

  assign points_pending = wr_ptr - rd_ptr;

  always @(posedge clk) begin
    map_point_t e;
    if (!rst_n) begin
      focal <= FOCAL_RST; centre <= CENTRE_RST; limits <= LIMITS_RST;
      qxy <= QXY_RST; qzw <= QZW_RST; tx <= 0; ty <= 0; tz <= 0;
      wr_ptr <= 0; rd_ptr <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FOCAL:   focal <= cfg_data[31:0];
          CFG_CENTRE:  centre <= cfg_data[31:0];
          CFG_LIMITS:  limits <= cfg_data;
          CFG_QUAT_XY: qxy <= cfg_data[31:0];
          CFG_QUAT_ZW: qzw <= cfg_data[31:0];
          CFG_TRANS_X: tx <= longint'(signed'(cfg_data[23:0]));
          CFG_TRANS_Y: ty <= longint'(signed'(cfg_data[23:0]));
          CFG_TRANS_Z: tz <= longint'(signed'(cfg_data[23:0]));
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_point();
      if (out_valid && out_ready) begin
        if (wr_ptr == rd_ptr) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected point %h %h %h label %h",
            out_point_x, out_point_y, out_point_z, out_point_label);
        end else begin
          e = point_mem[rd_ptr % EXP_DEPTH];
          rd_ptr <= rd_ptr + 1;
          if (e != {out_point_x, out_point_y, out_point_z, out_point_label}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("point mismatch: exp %h %h %h %h got %h %h %h %h", e.px, e.py,
                e.pz, e.lbl, out_point_x, out_point_y, out_point_z, out_point_label);
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

### sim/testbench.sv
// stimulus and verdict for the depth pixel back-projection
// depends on dpbp_pkg, depth_pixel_backprojection and dpbp_checker
module testbench;
  import dpbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  logic [DEPTH_W-1:0] in_depth = '0;
  logic in_depth_finite = 1'b0;
  logic [LABEL_W-1:0] in_label = '0;
  logic [11:0] in_pixel_col = '0, in_pixel_row = '0;
  logic [POINT_W-1:0] out_point_x, out_point_y, out_point_z;
  logic [LABEL_W-1:0] out_point_label;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, points_pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  longint cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  depth_pixel_backprojection u_top (.*);

  dpbp_checker u_checker (.*);

  // receiver stalls at random at the configured rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays high after the write; the next caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // one pixel transaction; random idle gap before it
  task automatic send_pixel(logic [19:0] z, logic fin, logic [7:0] lbl,
                            logic [11:0] col, logic [11:0] row);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_depth <= z;
    in_depth_finite <= fin;
    in_label <= lbl;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for all predicted points, then let dropped pixels flush out
  task automatic go_idle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] on_grid(int hi);
    return 12'(6 * $urandom_range(hi / 6));
  endfunction

  // mostly kept pixels with in-range depth, some dropped ones
  task automatic random_pixels(int count, int maxcoord);
    logic [11:0] col, row;
    logic [19:0] z;
    for (int i = 0; i < count; i++) begin
      col = on_grid(maxcoord);
      row = on_grid(maxcoord);
      z = 20'($urandom_range(1000, 60000));
      case ($urandom_range(9))
        0: col = 12'($urandom);
        1: row = 12'($urandom);
        2: z = 20'($urandom);
        3: begin
          col = on_grid(4095); row = on_grid(4095);
        end
        default: ;
      endcase
      send_pixel(z, $urandom_range(19) != 0, 8'($urandom), col, row);
    end
  endtask

  task automatic random_pose();
    write_reg(CFG_QUAT_XY, 40'($urandom));
    write_reg(CFG_QUAT_ZW, 40'($urandom));
    write_reg(CFG_TRANS_X, 40'($urandom));
    write_reg(CFG_TRANS_Y, 40'($urandom));
    write_reg(CFG_TRANS_Z, 40'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels at reset settings: extremes of each field
    send_idle_pct = 14; recv_idle_pct = 87;
    send_pixel(20'd1000, 1'b1, 8'h00, 12'd0, 12'd0);
    send_pixel(20'd60000, 1'b1, 8'hFF, 12'd4092, 12'd4092);
    send_pixel(20'd819, 1'b1, 8'h11, 12'd6, 12'd6);       // at min, dropped
    send_pixel(20'd820, 1'b1, 8'h12, 12'd6, 12'd6);
    send_pixel(20'd61440, 1'b1, 8'h13, 12'd6, 12'd6);     // at max, dropped
    send_pixel(20'd61439, 1'b1, 8'h14, 12'd6, 12'd6);
    send_pixel(20'hFFFFF, 1'b1, 8'h15, 12'd0, 12'd0);     // full depth, dropped
    send_pixel(20'd5000, 1'b0, 8'h16, 12'd0, 12'd0);      // not finite
    send_pixel(20'd5000, 1'b1, 8'h17, 12'd4095, 12'd0);   // off the stride grid
    send_pixel(20'd5000, 1'b1, 8'h18, 12'd0, 12'd7);
    send_pixel(20'd5000, 1'b1, 8'hAA, 12'd3, 12'd4095);
    go_idle();

    // extreme settings: tiny focal, wide limits, huge translation
    write_reg(CFG_FOCAL, 40'h0001_0001);
    write_reg(CFG_CENTRE, 40'hFFFF_FFFF);
    write_reg(CFG_LIMITS, 40'hFFFFF_00000);
    write_reg(CFG_TRANS_X, 40'h7FFFFF);
    write_reg(CFG_TRANS_Y, 40'h800000);
    write_reg(CFG_TRANS_Z, 40'h000001);
    send_pixel(20'hFFFFE, 1'b1, 8'h21, 12'd4092, 12'd0);  // back-projection saturates
    send_pixel(20'd1, 1'b1, 8'h22, 12'd0, 12'd4092);
    go_idle();
    // non-unit quaternion, three components at the extremes and one at -1
    write_reg(CFG_QUAT_XY, 40'h8000_7FFF);
    write_reg(CFG_QUAT_ZW, 40'hFFFF_8000);
    send_pixel(20'hFFFFE, 1'b1, 8'h23, 12'd4092, 12'd4092);
    send_pixel(20'd12345, 1'b1, 8'h24, 12'd6, 12'd600);
    go_idle();
    // zero focal lengths drop every pixel
    write_reg(CFG_FOCAL, 40'h0000_1F40);
    send_pixel(20'd5000, 1'b1, 8'h31, 12'd0, 12'd0);
    go_idle();
    write_reg(CFG_FOCAL, 40'h1F40_0000);
    send_pixel(20'd5000, 1'b1, 8'h32, 12'd0, 12'd0);
    go_idle();
    // min not below max
    write_reg(CFG_FOCAL, 40'h1F40_1F40);
    write_reg(CFG_LIMITS, 40'h00400_00400);
    send_pixel(20'd1024, 1'b1, 8'h33, 12'd0, 12'd0);
    go_idle();
    write_reg(CFG_LIMITS, 40'h00000_FFFFF);
    send_pixel(20'd1024, 1'b1, 8'h34, 12'd0, 12'd0);
    go_idle();

    // random phases, each under a new setting
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 87; recv_idle_pct = 14;
      end else if (ph == 8) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(CFG_FOCAL, {8'd0, 16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535))});
      if (ph % 3 == 0) write_reg(CFG_FOCAL, 40'h1F40_1F40);
      write_reg(CFG_CENTRE, 40'($urandom));
      write_reg(CFG_LIMITS, {20'($urandom_range(40000, 1048575)),
                             20'($urandom_range(0, 3000))});
      random_pose();
      random_pixels(145, ph % 4 == 3 ? 4095 : 600);
      go_idle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
